>>> rtl/tekd_pkg.sv
// Shared types, constants and phase codes for the terminal escape key decoder.
package tekd_pkg;

  localparam int LEGACY_FIELD_CHARS_DEF = 31;
  localparam int SGR_FIELD_CHARS_DEF    = 7;

  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_FKEY    = 3'd1;
  localparam logic [2:0] KIND_RPRESS  = 3'd2;
  localparam logic [2:0] KIND_RREL    = 3'd3;
  localparam logic [2:0] KIND_CLICK   = 3'd4;

  localparam logic [7:0] B_ALTV  = 8'hc3;
  localparam logic [7:0] B_CTLV  = 8'h16;
  localparam logic [7:0] B_CTLP  = 8'h10;
  localparam logic [7:0] B_CTLN  = 8'h0e;
  localparam logic [7:0] B_CTLF  = 8'h06;
  localparam logic [7:0] B_CTLB  = 8'h02;
  localparam logic [7:0] B_ESC   = 8'h1b;
  localparam logic [7:0] B_SS3   = 8'h4f;
  localparam logic [8:0] FK_BASE = 9'h0f1;
  localparam logic [7:0] B_TILDE = 8'h7e;
  localparam logic [15:0] SAT_MAX = 16'hffff;

  typedef enum logic [22:0] {
    PH_IDLE       = 23'd1 << 0,
    PH_SKIP_EMIT  = 23'd1 << 1,
    PH_ESC        = 23'd1 << 2,
    PH_SS3        = 23'd1 << 3,
    PH_CSI        = 23'd1 << 4,
    PH_CSI_BR     = 23'd1 << 5,
    PH_WHEEL      = 23'd1 << 6,
    PH_WAIT_M     = 23'd1 << 7,
    PH_CSI2       = 23'd1 << 8,
    PH_CSI2_SKIP  = 23'd1 << 9,
    PH_CSI1       = 23'd1 << 10,
    PH_CSI1_MOD   = 23'd1 << 11,
    PH_CSI1_ARROW = 23'd1 << 12,
    PH_CSI1_COLON = 23'd1 << 13,
    PH_SGR        = 23'd1 << 14,
    PH_LEG_SKIP1  = 23'd1 << 15,
    PH_LEG_CH2    = 23'd1 << 16,
    PH_LEG_X      = 23'd1 << 17,
    PH_LEG_Y      = 23'd1 << 18,
    PH_LEG_SKIPB  = 23'd1 << 19,
    PH_LEG_TAIL   = 23'd1 << 20,
    PH_LEG_TAIL2  = 23'd1 << 21,
    PH_LEG_WAITM  = 23'd1 << 22
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [8:0]  key;
    logic [3:0]  fkey;
    logic [15:0] click_x;
    logic [15:0] click_y;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Decimal accumulate with saturation at 65535.
  function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [7:0] b);
    logic [20:0] n;
    n = {5'd0, v} * 21'd10 + {17'd0, b[3:0]};
    return (n > 21'd65535) ? SAT_MAX : n[15:0];
  endfunction

endpackage

>>> rtl/tekd_if.sv
// Valid/ready channel interface carrying one payload.
interface tekd_if #(parameter type payload_t = logic [7:0]) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tekd_core.sv
// Per-byte decoder state machine with decimal field accumulators.
module tekd_core
  import tekd_pkg::*;
#(
  parameter int LEGACY_FIELD_CHARS = LEGACY_FIELD_CHARS_DEF,
  parameter int SGR_FIELD_CHARS    = SGR_FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);
  localparam int LW = $clog2(LEGACY_FIELD_CHARS + 1);
  localparam int SW = $clog2(SGR_FIELD_CHARS + 1);
  localparam int CW = (LW > SW) ? LW : SW;
  localparam logic [CW-1:0] LEG_MAX = CW'(LEGACY_FIELD_CHARS);
  localparam logic [CW-1:0] SGR_MAX = CW'(SGR_FIELD_CHARS);

  phase_t      phase, phase_next;
  logic [8:0]  pending_code, pending_code_next;
  logic [1:0]  field_index, field_index_next;
  logic [15:0] button_value, button_value_next;
  logic [15:0] x_accum, x_accum_next;
  logic [15:0] y_accum, y_accum_next;
  logic [CW-1:0] field_chars, field_chars_next;
  logic        digit_stop, digit_stop_next;

  logic [15:0] leg_acc, leg_acc_new;
  logic        leg_stop_new;
  logic [CW-1:0] leg_chars_new;
  logic        leg_done;
  logic [7:0]  b;
  logic [3:0]  lo;

  assign b  = in_byte;
  assign lo = in_byte[3:0];

  // One legacy field byte on whichever accumulator is active.
  always_comb begin
    leg_acc      = (phase == PH_LEG_X) ? x_accum : y_accum;
    leg_acc_new  = leg_acc;
    leg_stop_new = digit_stop;
    leg_chars_new = field_chars;
    leg_done     = 1'b0;
    if (b == ";" || b == "M") begin
      leg_done = 1'b1;
    end else begin
      if (!digit_stop) begin
        if (is_digit(b)) leg_acc_new = add_digit(leg_acc, b);
        else leg_stop_new = 1'b1;
      end
      leg_chars_new = field_chars + 1'b1;
      leg_done = (leg_chars_new >= LEG_MAX);
    end
  end

  always_comb begin
    logic em;
    result_t r;
    em = 1'b0;
    r  = '0;
    phase_next        = phase;
    pending_code_next = pending_code;
    field_index_next  = field_index;
    button_value_next = button_value;
    x_accum_next      = x_accum;
    y_accum_next      = y_accum;
    field_chars_next  = field_chars;
    digit_stop_next   = digit_stop;

    unique case (phase)
      PH_IDLE: begin
        em = 1'b1;
        case (b)
          B_ALTV: begin em = 1'b0; pending_code_next = 9'("K"); phase_next = PH_SKIP_EMIT; end
          B_CTLV: r.key = 9'("J");
          B_CTLP: r.key = 9'("k");
          B_CTLN: r.key = 9'("j");
          B_CTLF: r.key = 9'("l");
          B_CTLB: r.key = 9'("h");
          B_ESC:  begin em = 1'b0; phase_next = PH_ESC; end
          default: r.key = {1'b0, b};
        endcase
      end
      PH_SKIP_EMIT: begin em = 1'b1; r.key = pending_code; end
      PH_ESC: begin
        if (b == B_ESC) begin em = 1'b1; r.key = 9'("q"); end
        else if (b == B_SS3) phase_next = PH_SS3;
        else if (b == "[") phase_next = PH_CSI;
        else begin em = 1'b1; r.key = {1'b0, b}; end
      end
      PH_SS3: begin
        em = 1'b1;
        case (b)
          "A": r.key = 9'("k");
          "B": r.key = 9'("j");
          "C": r.key = 9'("l");
          "D": r.key = 9'("h");
          default: begin
            if (lo < 4'd12) begin r.kind = KIND_FKEY; r.fkey = lo + 4'd1; end
            else r.key = FK_BASE + {5'd0, lo};
          end
        endcase
      end
      PH_CSI: begin
        em = 1'b0;
        case (b)
          "<": begin
            field_index_next = '0; button_value_next = '0; x_accum_next = '0;
            y_accum_next = '0; field_chars_next = '0; digit_stop_next = 1'b0;
            phase_next = PH_SGR;
          end
          "[": phase_next = PH_CSI_BR;
          "9": phase_next = PH_WHEEL;
          "3", "M": phase_next = PH_LEG_SKIP1;
          "2": phase_next = PH_CSI2;
          "1": phase_next = PH_CSI1;
          "5": begin pending_code_next = 9'("K"); phase_next = PH_SKIP_EMIT; end
          "6": begin pending_code_next = 9'("J"); phase_next = PH_SKIP_EMIT; end
          "A": begin em = 1'b1; r.key = 9'("k"); end
          "B": begin em = 1'b1; r.key = 9'("j"); end
          "C": begin em = 1'b1; r.key = 9'("l"); end
          "D": begin em = 1'b1; r.key = 9'("h"); end
          "a": begin em = 1'b1; r.key = 9'("K"); end
          "b": begin em = 1'b1; r.key = 9'("J"); end
          "c": begin em = 1'b1; r.key = 9'("L"); end
          "d": begin em = 1'b1; r.key = 9'("H"); end
          default: begin em = 1'b1; r.key = {1'b0, b}; end
        endcase
      end
      PH_CSI_BR: begin
        em = 1'b1;
        r.kind = KIND_FKEY;
        case (b)
          "2": r.fkey = 4'd11;
          "A": r.fkey = 4'd1;
          "B": r.fkey = 4'd2;
          "C": r.fkey = 4'd3;
          "D": r.fkey = 4'd4;
          default: begin r.kind = KIND_KEY; r.key = {1'b0, b}; end
        endcase
      end
      PH_WHEEL: begin
        pending_code_next = (b == "6") ? 9'("k") : (b == "7") ? 9'("j") : 9'd0;
        phase_next = PH_WAIT_M;
      end
      PH_WAIT_M: begin
        if (b == "M") begin em = 1'b1; r.key = pending_code; end
      end
      PH_CSI2: begin
        if (b == B_TILDE) begin em = 1'b1; r.kind = KIND_FKEY; r.fkey = 4'd12; end
        else begin pending_code_next = {1'b0, b}; phase_next = PH_CSI2_SKIP; end
      end
      PH_CSI2_SKIP: begin
        em = 1'b1;
        r.kind = KIND_FKEY;
        case (pending_code)
          9'("0"): r.fkey = 4'd9;
          9'("1"): r.fkey = 4'd10;
          9'("3"): r.fkey = 4'd11;
          default: begin r.kind = KIND_KEY; r.key = pending_code; end
        endcase
      end
      PH_CSI1: begin
        em = 1'b1;
        r.kind = KIND_FKEY;
        case (b)
          "1": r.fkey = 4'd1;
          "2": r.fkey = 4'd2;
          "3": r.fkey = 4'd3;
          "4": r.fkey = 4'd4;
          "5": r.fkey = 4'd5;
          "7": r.fkey = 4'd6;
          "8": r.fkey = 4'd7;
          "9": r.fkey = 4'd8;
          ";": begin em = 1'b0; r.kind = KIND_KEY; phase_next = PH_CSI1_MOD; end
          ":": begin em = 1'b0; r.kind = KIND_KEY; phase_next = PH_CSI1_COLON; end
          default: begin r.kind = KIND_KEY; r.key = {1'b0, b}; end
        endcase
      end
      PH_CSI1_MOD: begin
        if (b == "2") phase_next = PH_CSI1_ARROW;
        else begin em = 1'b1; r.key = {1'b0, b}; end
      end
      PH_CSI1_COLON: phase_next = PH_CSI1_ARROW;
      PH_CSI1_ARROW: begin
        em = 1'b1;
        case (b)
          "A": r.key = 9'("K");
          "B": r.key = 9'("J");
          "C": r.key = 9'("L");
          "D": r.key = 9'("H");
          default: r.key = {1'b0, b};
        endcase
      end
      PH_SGR: begin
        logic [15:0] btn, yv;
        btn = button_value;
        yv  = y_accum;
        if (field_index != 2'd0) begin
          if (is_digit(b) && field_chars < SGR_MAX) begin
            yv = add_digit(y_accum, b);
            y_accum_next = yv;
            field_chars_next = field_chars + 1'b1;
          end
        end else if (field_chars < SGR_MAX) begin
          if (!digit_stop) begin
            if (is_digit(b)) begin btn = add_digit(button_value, b); button_value_next = btn; end
            else digit_stop_next = 1'b1;
          end
          field_chars_next = field_chars + 1'b1;
        end
        if (b == ";") begin
          if (field_index == 2'd1) x_accum_next = y_accum;
          if (field_index < 2'd2) field_index_next = field_index + 2'd1;
          y_accum_next = '0;
          field_chars_next = '0;
          digit_stop_next = 1'b0;
        end
        if (b == "M" || b == "m") begin
          em = 1'b1;
          case (btn)
            16'd2:  r.kind = (b == "m") ? KIND_RREL : KIND_RPRESS;
            16'd64: r.key = 9'("k");
            16'd65: r.key = 9'("j");
            16'd66, 16'd80: r.key = 9'("h");
            16'd67, 16'd81: r.key = 9'("l");
            default: begin
              if (b == "m") begin
                r.kind = KIND_CLICK; r.click_x = x_accum; r.click_y = yv;
              end
            end
          endcase
        end
      end
      PH_LEG_SKIP1: phase_next = PH_LEG_CH2;
      PH_LEG_CH2: begin
        if (b != ";") em = 1'b1;
        else begin
          x_accum_next = '0; y_accum_next = '0;
          field_chars_next = '0; digit_stop_next = 1'b0;
          phase_next = PH_LEG_X;
        end
      end
      PH_LEG_X: begin
        x_accum_next = leg_acc_new;
        field_chars_next = leg_chars_new;
        digit_stop_next = leg_stop_new;
        if (leg_done) begin
          field_chars_next = '0; digit_stop_next = 1'b0; phase_next = PH_LEG_Y;
        end
      end
      PH_LEG_Y: begin
        y_accum_next = leg_acc_new;
        field_chars_next = leg_chars_new;
        digit_stop_next = leg_stop_new;
        if (leg_done) phase_next = PH_LEG_SKIPB;
      end
      PH_LEG_SKIPB: phase_next = PH_LEG_TAIL;
      PH_LEG_TAIL, PH_LEG_TAIL2: begin
        if (b == B_ESC && phase == PH_LEG_TAIL) phase_next = PH_LEG_TAIL2;
        else if (b == "[") phase_next = PH_LEG_WAITM;
        else begin em = 1'b1; r.kind = KIND_CLICK; r.click_x = x_accum; r.click_y = y_accum; end
      end
      PH_LEG_WAITM: begin
        if (b == "M") begin
          em = 1'b1; r.kind = KIND_CLICK; r.click_x = x_accum; r.click_y = y_accum;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    if (em) phase_next = PH_IDLE;
    res_valid = em;
    res = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_code <= '0;
      field_index  <= '0;
      button_value <= '0;
      x_accum      <= '0;
      y_accum      <= '0;
      field_chars  <= '0;
      digit_stop   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      pending_code <= pending_code_next;
      field_index  <= field_index_next;
      button_value <= button_value_next;
      x_accum      <= x_accum_next;
      y_accum      <= y_accum_next;
      field_chars  <= field_chars_next;
      digit_stop   <= digit_stop_next;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> phase == PH_IDLE)
    else $error("no return to idle after result");
  a_fidx: assert property (@(posedge clk) disable iff (rst) field_index != 2'd3)
    else $error("field index overflow");
`endif
endmodule

>>> rtl/tekd_out_reg.sv
// Result register with skid stage so the input keeps flowing while a result waits.
module tekd_out_reg
  import tekd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_take,
  tekd_if.source  out_ch
);
  logic    main_v, skid_v;
  result_t main_d, skid_d;

  // Accept new work whenever the skid slot is free.
  assign can_take     = !skid_v;
  assign out_ch.valid = main_v;
  assign out_ch.data  = main_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || out_ch.ready) begin
        main_v <= skid_v || push;
        skid_v <= 1'b0;
      end else if (push) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || out_ch.ready) main_d <= skid_v ? skid_d : push_data;
    else if (push) skid_d <= push_data;
  end

`ifndef ASSERT_OFF
  a_no_drop: assert property (@(posedge clk) disable iff (rst) !(push && skid_v))
    else $error("push into full skid");
  a_skid_main: assert property (@(posedge clk) disable iff (rst) skid_v |-> main_v)
    else $error("skid holds data while output empty");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    main_v && !out_ch.ready |=> main_v)
    else $error("result lost while stalled");
`endif
endmodule

>>> rtl/terminal_escape_key_decoder.sv
// Top level of the terminal escape key decoder.
// Usage:
//   in_ch carries one raw terminal byte per transfer (valid/ready).
//   out_ch carries one decoded result (kind, key, fkey, click_x, click_y).
//   Each byte updates the decoder state in the cycle it is taken; a byte
//   that completes a sequence yields one result, others yield none.
//   A result goes into the result register, or into the skid while out_ch
//   stalls, before it shows on out_ch. Throughput: one byte per cycle while
//   in_ch.ready is high; the state update sits before the result register.
//   A two-entry output stage (result register plus skid) lets input keep
//   flowing while one result waits; when both are full in_ch.ready drops
//   and stays low until the receiver takes a result.
//   Reset (rst, synchronous) returns the decoder to idle with all
//   accumulators zero and empties the output stage.
//   Coordinates saturate at 65535.
module terminal_escape_key_decoder
  import tekd_pkg::*;
#(
  parameter int LEGACY_FIELD_CHARS = LEGACY_FIELD_CHARS_DEF,
  parameter int SGR_FIELD_CHARS    = SGR_FIELD_CHARS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  tekd_if.sink   in_ch,
  tekd_if.source out_ch
);
  logic    can_take, step, res_valid;
  result_t res;

  // Advance on every input transfer.
  assign in_ch.ready = can_take;
  assign step        = in_ch.valid && can_take;

  tekd_core #(
    .LEGACY_FIELD_CHARS(LEGACY_FIELD_CHARS),
    .SGR_FIELD_CHARS(SGR_FIELD_CHARS)
  ) u_core (
    .clk(clk), .rst(rst), .step(step), .in_byte(in_ch.data),
    .res_valid(res_valid), .res(res)
  );

  tekd_out_reg u_out (
    .clk(clk), .rst(rst), .push(step && res_valid), .push_data(res),
    .can_take(can_take), .out_ch(out_ch)
  );
endmodule
